/* hdl/csma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSMA/CA transmit sequencer package
// Shared widths, reset values, codes and interface structs of the sequencer,
// its serial modulo unit and the top level.
// ----------------------------------------------------------------------------
package csma_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned QUEUE_DEPTH_DEF   = 16;
  localparam int unsigned MAX_EXP_DEF       = 10;
  localparam int unsigned COUNTER_WIDTH_DEF = 32;

  // Field and register widths.
  localparam int unsigned SLOT_W       = 8;
  localparam int unsigned FRAME_W      = 10;
  localparam int unsigned CW_MIN_W     = 10;
  localparam int unsigned CW_MAX_W     = 20;
  localparam int unsigned RND_W        = 31;
  localparam int unsigned RETRY_W      = 4;
  localparam int unsigned PHASE_W      = 3;
  localparam int unsigned FRAMES_OUT_W = 5;
  localparam int unsigned TOTAL_OUT_W  = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 20;
  localparam int unsigned MOD_CNT_W    = $clog2(RND_W + 1);

  localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

  // Register values after reset.
  localparam logic [SLOT_W-1:0]   DIFS_RST   = SLOT_W'(2);
  localparam logic [SLOT_W-1:0]   SIFS_RST   = SLOT_W'(1);
  localparam logic [SLOT_W-1:0]   ACK_RST    = SLOT_W'(2);
  localparam logic [FRAME_W-1:0]  FRAME_RST  = FRAME_W'(100);
  localparam logic [CW_MIN_W-1:0] CW_MIN_RST = CW_MIN_W'(4);
  localparam logic [CW_MAX_W-1:0] CW_MAX_RST = CW_MAX_W'(1024);

  // Channel phases as shown on the result word.
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_DIFS    = 3'd1,
    PH_BACKOFF = 3'd2,
    PH_SEND    = 3'd3,
    PH_SIFS    = 3'd4,
    PH_ACK     = 3'd5
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFS   = 3'd0,
    CFG_SIFS   = 3'd1,
    CFG_ACK    = 3'd2,
    CFG_FRAME  = 3'd3,
    CFG_CW_MIN = 3'd4,
    CFG_CW_MAX = 3'd5
  } cfg_idx_e;

  // Sequencer control states.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_WALK,
    SEQ_DRAW,
    SEQ_DRAW_WAIT,
    SEQ_DONE
  } seq_state_e;

  // Modulo unit states.
  typedef enum logic [1:0] {
    MOD_IDLE,
    MOD_RUN,
    MOD_FINISH
  } mod_state_e;

  typedef struct packed {
    logic [SLOT_W-1:0]   difs;
    logic [SLOT_W-1:0]   sifs;
    logic [SLOT_W-1:0]   ack;
    logic [FRAME_W-1:0]  frame;
    logic [CW_MIN_W-1:0] cw_min;
    logic [CW_MAX_W-1:0] cw_max;
  } cfg_t;

  typedef struct packed {
    logic                start;
    logic [RND_W-1:0]    dividend;
    logic [CW_MAX_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic                done;
    logic [CW_MAX_W-1:0] remainder;
  } mod_rsp_t;

  typedef struct packed {
    phase_e                  phase;
    logic [FRAMES_OUT_W-1:0] frames;
    logic                    overflow;
    logic [TOTAL_OUT_W-1:0]  success;
    logic [TOTAL_OUT_W-1:0]  collision;
  } res_t;

endpackage
`default_nettype wire

/* hdl/csma_ca_transmit_sequencer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSMA/CA transmit sequencer, top level
// Configuration registers, phase sequencer, serial modulo unit and the
// registered result word.
// ----------------------------------------------------------------------------
// Each input word is one slot tick and gives exactly one result word. After a
// tick is taken, the phase walk moves through at most twelve phase steps, and
// every backoff draw at the end of an ACK wait runs in the bit-serial modulo
// unit, which reduces the 31-bit random word one bit per cycle; the result is
// then handed over, subject to any output stall. The input is stalled from
// acceptance until the result is placed in the output register, which then
// holds it while the next tick is already taken.
// Configuration registers may be written at any time the block is idle. Writes
// take effect at counter reloads in the walk, window limits at a backoff draw.
module csma_ca_transmit_sequencer_top #(
  parameter int unsigned QUEUE_DEPTH   = csma_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_EXPONENT  = csma_pkg::MAX_EXP_DEF,
  parameter int unsigned COUNTER_WIDTH = csma_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [csma_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [csma_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Slot tick input.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              frame_arrival_i,
  input  logic                              collision_seen_i,
  input  logic [csma_pkg::RND_W-1:0]        random_word_i,
  // Result output.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [csma_pkg::PHASE_W-1:0]      phase_o,
  output logic [csma_pkg::FRAMES_OUT_W-1:0] frames_waiting_o,
  output logic                              queue_overflow_o,
  output logic [csma_pkg::TOTAL_OUT_W-1:0]  success_total_o,
  output logic [csma_pkg::TOTAL_OUT_W-1:0]  collision_total_o
);
  import csma_pkg::*;

  cfg_t     cfg_q, cfg_d;
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;
  res_t     res;
  res_t     out_q;
  logic     out_valid_q, out_valid_d;
  logic     res_valid;
  logic     res_ready;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DIFS:   cfg_d.difs   = cfg_data_i[SLOT_W-1:0];
        CFG_SIFS:   cfg_d.sifs   = cfg_data_i[SLOT_W-1:0];
        CFG_ACK:    cfg_d.ack    = cfg_data_i[SLOT_W-1:0];
        CFG_FRAME:  cfg_d.frame  = cfg_data_i[FRAME_W-1:0];
        CFG_CW_MIN: cfg_d.cw_min = cfg_data_i[CW_MIN_W-1:0];
        CFG_CW_MAX: cfg_d.cw_max = cfg_data_i[CW_MAX_W-1:0];
        default:    cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.difs   <= DIFS_RST;
      cfg_q.sifs   <= SIFS_RST;
      cfg_q.ack    <= ACK_RST;
      cfg_q.frame  <= FRAME_RST;
      cfg_q.cw_min <= CW_MIN_RST;
      cfg_q.cw_max <= CW_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Phase sequencer.
  csma_seq #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .MAX_EXPONENT (MAX_EXPONENT),
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .frame_arrival_i (frame_arrival_i),
    .collision_seen_i(collision_seen_i),
    .random_word_i   (random_word_i),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res),
    .mod_req_o       (mod_req),
    .mod_rsp_i       (mod_rsp)
  );

  // Serial modulo unit for backoff draws.
  csma_mod_unit u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mod_req),
    .rsp_o (mod_rsp)
  );

  // Output register: free when empty or when its word leaves this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign phase_o           = out_q.phase;
  assign frames_waiting_o  = out_q.frames;
  assign queue_overflow_o  = out_q.overflow;
  assign success_total_o   = out_q.success;
  assign collision_total_o = out_q.collision;

endmodule
`default_nettype wire

/* hdl/csma_mod_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSMA serial modulo unit
// Restoring remainder of the random word by the contention window, one
// dividend bit per cycle. A zero divisor gives a zero remainder without a run.
// ----------------------------------------------------------------------------
module csma_mod_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csma_pkg::mod_req_t req_i,
  output csma_pkg::mod_rsp_t rsp_o
);
  import csma_pkg::*;

  mod_state_e           state_q, state_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [RND_W-1:0]     src_q, src_d;
  logic [CW_MAX_W-1:0]  div_q, div_d;
  logic [CW_MAX_W-1:0]  rem_q, rem_d;
  logic [CW_MAX_W:0]    trial;
  logic [CW_MAX_W:0]    trial_diff;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MOD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  // One restoring step: bring in the next dividend bit and subtract if it fits.
  assign trial      = {rem_q, src_q[RND_W-1]};
  assign trial_diff = trial - {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    src_d   = src_q;
    div_d   = div_q;
    rem_d   = rem_q;
    unique case (state_q)
      MOD_IDLE: begin
        if (req_i.start) begin
          src_d = req_i.dividend;
          div_d = req_i.divisor;
          rem_d = '0;
          cnt_d = MOD_CNT_W'(RND_W);
          if (req_i.divisor == '0) begin
            state_d = MOD_FINISH;
          end else begin
            state_d = MOD_RUN;
          end
        end
      end
      MOD_RUN: begin
        if (trial >= {1'b0, div_q}) begin
          rem_d = trial_diff[CW_MAX_W-1:0];
        end else begin
          rem_d = trial[CW_MAX_W-1:0];
        end
        src_d = {src_q[RND_W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == MOD_CNT_W'(1)) begin
          state_d = MOD_FINISH;
        end
      end
      MOD_FINISH: begin
        state_d = MOD_IDLE;
      end
      default: begin
        state_d = MOD_IDLE;
      end
    endcase
  end

  assign rsp_o.done      = (state_q == MOD_FINISH);
  assign rsp_o.remainder = rem_q;

endmodule
`default_nettype wire

/* hdl/csma_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSMA phase sequencer
// Holds the queue count, phase and wait counters. Per slot tick it walks the
// phases one step per cycle until a counter is decremented, the queue is empty
// or the ACK end recurs, pausing for the modulo unit's backoff draw at ACK end.
// ----------------------------------------------------------------------------
module csma_seq #(
  parameter int unsigned QUEUE_DEPTH   = csma_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_EXPONENT  = csma_pkg::MAX_EXP_DEF,
  parameter int unsigned COUNTER_WIDTH = csma_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  csma_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       frame_arrival_i,
  input  logic                       collision_seen_i,
  input  logic [csma_pkg::RND_W-1:0] random_word_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output csma_pkg::res_t             res_o,
  output csma_pkg::mod_req_t         mod_req_o,
  input  csma_pkg::mod_rsp_t         mod_rsp_i
);
  import csma_pkg::*;

  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EXP_W  = $clog2(MAX_EXPONENT + 1);
  localparam int unsigned K_W    = (EXP_W > RETRY_W) ? EXP_W : RETRY_W;
  localparam int unsigned WIN_W  = CW_MIN_W + MAX_EXPONENT;
  localparam int unsigned CMP_W  = (WIN_W > CW_MAX_W) ? WIN_W : CW_MAX_W;

  localparam logic [QCNT_W-1:0]        QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);
  localparam logic [COUNTER_WIDTH-1:0] COUNT_MAX  = '1;
  localparam logic [K_W-1:0]           EXP_LIMIT  = K_W'(MAX_EXPONENT);

  seq_state_e               state_q, state_d;
  phase_e                   phase_q, phase_d;
  logic [QCNT_W-1:0]        queue_q, queue_d;
  logic [SLOT_W-1:0]        difs_q, difs_d;
  logic [SLOT_W-1:0]        sifs_q, sifs_d;
  logic [SLOT_W-1:0]        ack_q, ack_d;
  logic [FRAME_W-1:0]       frame_q, frame_d;
  logic [CW_MAX_W-1:0]      backoff_q, backoff_d;
  logic [RETRY_W-1:0]       retry_q, retry_d;
  logic                     pending_q, pending_d;
  logic                     acked_q, acked_d;
  logic                     draw_coll_q, draw_coll_d;
  logic                     overflow_q, overflow_d;
  logic [COUNTER_WIDTH-1:0] succ_q, succ_d;
  logic [COUNTER_WIDTH-1:0] coll_q, coll_d;
  logic [RND_W-1:0]         rnd_q, rnd_d;

  logic [K_W-1:0]      retry_ext;
  logic [K_W-1:0]      win_exp;
  logic [WIN_W-1:0]    win_shift;
  logic [WIN_W-1:0]    win_m1;
  logic [CMP_W-1:0]    win_cmp;
  logic [CW_MAX_W-1:0] coll_divisor;
  logic [CW_MAX_W-1:0] succ_divisor;

  // Control and counter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      phase_q     <= PH_IDLE;
      queue_q     <= '0;
      difs_q      <= DIFS_RST;
      sifs_q      <= SIFS_RST;
      ack_q       <= ACK_RST;
      frame_q     <= FRAME_RST;
      backoff_q   <= '0;
      retry_q     <= '0;
      pending_q   <= 1'b0;
      acked_q     <= 1'b0;
      draw_coll_q <= 1'b0;
      overflow_q  <= 1'b0;
      succ_q      <= '0;
      coll_q      <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      queue_q     <= queue_d;
      difs_q      <= difs_d;
      sifs_q      <= sifs_d;
      ack_q       <= ack_d;
      frame_q     <= frame_d;
      backoff_q   <= backoff_d;
      retry_q     <= retry_d;
      pending_q   <= pending_d;
      acked_q     <= acked_d;
      draw_coll_q <= draw_coll_d;
      overflow_q  <= overflow_d;
      succ_q      <= succ_d;
      coll_q      <= coll_d;
    end
  end

  // The random word of the current tick.
  always_ff @(posedge clk_i) begin
    rnd_q <= rnd_d;
  end

  // Backoff window. The retry count is already updated when this is used.
  assign retry_ext = K_W'(retry_q);
  assign win_exp   = (retry_ext > EXP_LIMIT) ? EXP_LIMIT : retry_ext;
  assign win_shift = WIN_W'(cfg_i.cw_min) << win_exp;
  assign win_m1    = (win_shift == '0) ? '0 : win_shift - 1'b1;
  assign win_cmp   = CMP_W'(win_m1);

  assign coll_divisor = (win_cmp > CMP_W'(cfg_i.cw_max)) ? cfg_i.cw_max
                                                         : CW_MAX_W'(win_m1);
  assign succ_divisor = (cfg_i.cw_min < CW_MIN_W'(2)) ? '0
                                                      : CW_MAX_W'(cfg_i.cw_min - 1'b1);

  // The modulo unit is started in the single draw state.
  assign mod_req_o.start    = (state_q == SEQ_DRAW);
  assign mod_req_o.dividend = rnd_q;
  assign mod_req_o.divisor  = draw_coll_q ? coll_divisor : succ_divisor;

  // Sequencer: tick intake, phase walk, backoff draw and result hand-off.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    queue_d     = queue_q;
    difs_d      = difs_q;
    sifs_d      = sifs_q;
    ack_d       = ack_q;
    frame_d     = frame_q;
    backoff_d   = backoff_q;
    retry_d     = retry_q;
    pending_d   = pending_q;
    acked_d     = acked_q;
    draw_coll_d = draw_coll_q;
    overflow_d  = overflow_q;
    succ_d      = succ_q;
    coll_d      = coll_q;
    rnd_d       = rnd_q;
    res_valid_o = 1'b0;

    unique case (state_q)
      SEQ_IDLE: begin
        if (in_valid_i) begin
          overflow_d = 1'b0;
          if (frame_arrival_i) begin
            if (queue_q < QUEUE_FULL) begin
              queue_d = queue_q + 1'b1;
            end else begin
              overflow_d = 1'b1;
            end
          end
          if (collision_seen_i) begin
            pending_d = 1'b1;
          end
          rnd_d   = random_word_i;
          acked_d = 1'b0;
          state_d = SEQ_WALK;
        end
      end

      SEQ_WALK: begin
        unique case (phase_q)
          PH_DIFS: begin
            if (difs_q != '0) begin
              difs_d  = difs_q - 1'b1;
              state_d = SEQ_DONE;
            end else begin
              phase_d = PH_BACKOFF;
            end
          end
          PH_BACKOFF: begin
            if (backoff_q != '0) begin
              backoff_d = backoff_q - 1'b1;
              state_d   = SEQ_DONE;
            end else begin
              frame_d = cfg_i.frame;
              phase_d = PH_SEND;
            end
          end
          PH_SEND: begin
            if (frame_q != '0) begin
              frame_d = frame_q - 1'b1;
              state_d = SEQ_DONE;
            end else begin
              phase_d = PH_SIFS;
            end
          end
          PH_SIFS: begin
            if (sifs_q != '0) begin
              sifs_d  = sifs_q - 1'b1;
              state_d = SEQ_DONE;
            end else begin
              phase_d = PH_ACK;
            end
          end
          PH_ACK: begin
            if (ack_q != '0) begin
              ack_d   = ack_q - 1'b1;
              state_d = SEQ_DONE;
            end else if (acked_q) begin
              // Only one ACK end is taken per tick.
              state_d = SEQ_DONE;
            end else begin
              acked_d = 1'b1;
              if (pending_q) begin
                if (coll_q != COUNT_MAX) begin
                  coll_d = coll_q + 1'b1;
                end
                if (retry_q != RETRY_MAX) begin
                  retry_d = retry_q + 1'b1;
                end
                draw_coll_d = 1'b1;
              end else begin
                retry_d = '0;
                if (queue_q != '0) begin
                  queue_d = queue_q - 1'b1;
                end
                if (succ_q != COUNT_MAX) begin
                  succ_d = succ_q + 1'b1;
                end
                draw_coll_d = 1'b0;
              end
              difs_d    = cfg_i.difs;
              sifs_d    = cfg_i.sifs;
              ack_d     = cfg_i.ack;
              frame_d   = cfg_i.frame;
              pending_d = 1'b0;
              phase_d   = PH_IDLE;
              state_d   = SEQ_DRAW;
            end
          end
          default: begin
            if (queue_q != '0) begin
              phase_d = PH_DIFS;
            end else begin
              phase_d = PH_IDLE;
              state_d = SEQ_DONE;
            end
          end
        endcase
      end

      SEQ_DRAW: begin
        state_d = SEQ_DRAW_WAIT;
      end

      SEQ_DRAW_WAIT: begin
        if (mod_rsp_i.done) begin
          backoff_d = mod_rsp_i.remainder;
          state_d   = SEQ_WALK;
        end
      end

      SEQ_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = SEQ_IDLE;
        end
      end

      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != SEQ_IDLE);

  // Result word of the finished tick.
  assign res_o.phase     = phase_q;
  assign res_o.frames    = FRAMES_OUT_W'(queue_q);
  assign res_o.overflow  = overflow_q;
  assign res_o.success   = TOTAL_OUT_W'(succ_q);
  assign res_o.collision = TOTAL_OUT_W'(coll_q);

`ifndef SYNTHESIS
  // The queue never holds more frames than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) queue_q <= QUEUE_FULL)
    else $error("csma_seq: queue count above depth");

  // A tick that ends in idle does so only with an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_DONE && phase_q == PH_IDLE) |-> queue_q == '0)
    else $error("csma_seq: tick ended idle with frames queued");

  // The modulo unit answers only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp_i.done |-> state_q == SEQ_DRAW_WAIT)
    else $error("csma_seq: unexpected modulo result");

  // A drawn backoff lies below its window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_rsp_i.done && mod_req_o.divisor != '0) |->
      mod_rsp_i.remainder < mod_req_o.divisor)
    else $error("csma_seq: backoff not below window");

  // An ACK end is only taken during the phase walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(acked_q) |-> $past(state_q) == SEQ_WALK)
    else $error("csma_seq: ACK end outside the phase walk");
`endif

endmodule
`default_nettype wire
